FILE: rtl/core/ktw_pkg.sv
// Shared types, constants and glyph mapping helper for the kerned text width block.
// No dependencies; every other file of the block takes names from here by scope.
package ktw_pkg;

  localparam int GLYPH_COUNT_DEF = 98;
  localparam int GLYPH_W         = 7;
  localparam int OP_W            = 2;
  localparam int CHAR_W          = 8;
  localparam int IDX_W           = 14;
  localparam int VAL_W           = 8;
  localparam int SUM_W           = 16;

  localparam logic [VAL_W-1:0]   KERN            = 8'd2;
  localparam logic [VAL_W-1:0]   SPACE_WIDTH_RST = 8'd3;
  localparam logic [GLYPH_W-1:0] CURLY_SINGLE    = 7'd96;
  localparam logic [GLYPH_W-1:0] CURLY_DOUBLE    = 7'd97;
  localparam logic [CHAR_W-1:0]  CODE_BASE       = 8'd32;
  localparam logic [CHAR_W-1:0]  CH_UNDERSCORE   = 8'd95;
  localparam logic [CHAR_W-1:0]  CH_SQUOTE       = 8'd39;
  localparam logic [CHAR_W-1:0]  CH_DQUOTE       = 8'd34;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_CHAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_END   = 2'd2;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_SPACE,
    KIND_KERN,
    KIND_END
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } stage_t;

  // code - 32 clamped to 0..top; negative bytes and control codes give glyph 0
  function automatic logic [GLYPH_W-1:0] clamp_code(input logic [CHAR_W-1:0] code,
                                                    input logic [GLYPH_W-1:0] top);
    logic [CHAR_W-1:0] diff;
    logic [GLYPH_W-1:0] g;
    diff = code - CODE_BASE;
    g    = diff[GLYPH_W-1:0];
    if (code[CHAR_W-1] || (code < CODE_BASE)) begin
      return '0;
    end
    return (g > top) ? top : g;
  endfunction

endpackage

FILE: rtl/core/ktw_if.sv
// Valid/ready channel interfaces for the input and result transactions.
// Depends on ktw_pkg for the field widths.
interface ktw_in_if;
  logic                         valid;
  logic                         ready;
  logic [ktw_pkg::OP_W-1:0]     op;
  logic [ktw_pkg::CHAR_W-1:0]   char_code;
  logic [ktw_pkg::IDX_W-1:0]    table_index;
  logic [ktw_pkg::VAL_W-1:0]    table_value;

  modport source (output valid, op, char_code, table_index, table_value, input ready);
  modport sink   (input valid, op, char_code, table_index, table_value, output ready);
endinterface

interface ktw_out_if;
  logic                         valid;
  logic                         ready;
  logic [ktw_pkg::SUM_W-1:0]    string_width;

  modport source (output valid, string_width, input ready);
  modport sink   (input valid, string_width, output ready);
endinterface

FILE: rtl/core/kerned_text_width_measure.sv
// Top level of the kerned text width block: ktw_front and ktw_accum joined.
// Depends on ktw_pkg, ktw_in_if/ktw_out_if, ktw_front and ktw_accum.
//
//  channel   dir  handshake            payload
//  in_chan   in   valid/ready          op, char_code, table_index, table_value
//  out_chan  out  valid/ready          string_width
//  cfg       in   cfg_we               cfg_wdata (space_width)
//
// One transaction per cycle while in_chan.ready is high; the result of an end transaction
// passes the input register, then the registered table read, then the result register.
// The advance table is one memory with one write port and one registered read port.
// in_chan.ready drops only while an end transaction waits on an untaken result.
// Synchronous active-low reset; the table holds no reset value.
module kerned_text_width_measure #(
  parameter int GLYPH_COUNT = ktw_pkg::GLYPH_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ktw_in_if.sink                     in_chan,
  ktw_out_if.source                  out_chan,
  input  logic                       cfg_we,
  input  logic [ktw_pkg::VAL_W-1:0]  cfg_wdata
);

  ktw_pkg::stage_t            st;
  logic [ktw_pkg::VAL_W-1:0]  rd_data;
  logic                       adv;

  assign in_chan.ready = adv;

  ktw_front #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_chan.valid),
    .in_op    (in_chan.op),
    .in_char  (in_chan.char_code),
    .in_idx   (in_chan.table_index),
    .in_val   (in_chan.table_value),
    .st       (st),
    .rd_data  (rd_data)
  );

  ktw_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .st        (st),
    .rd_data   (rd_data),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_width (out_chan.string_width),
    .adv       (adv)
  );

endmodule

FILE: rtl/core/ktw_front.sv
// Input register, glyph mapping, previous-glyph tracking and the advance table memory.
// Depends on ktw_pkg; feeds ktw_accum with a stage_t and the registered table read.
module ktw_front #(
  parameter int GLYPH_COUNT = ktw_pkg::GLYPH_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [ktw_pkg::OP_W-1:0]    in_op,
  input  logic [ktw_pkg::CHAR_W-1:0]  in_char,
  input  logic [ktw_pkg::IDX_W-1:0]   in_idx,
  input  logic [ktw_pkg::VAL_W-1:0]   in_val,
  output ktw_pkg::stage_t             st,
  output logic [ktw_pkg::VAL_W-1:0]   rd_data
);

  localparam int DEPTH = GLYPH_COUNT * GLYPH_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [ktw_pkg::GLYPH_W-1:0] CHAR_TOP = ktw_pkg::GLYPH_W'(GLYPH_COUNT - 3);
  localparam logic [ktw_pkg::GLYPH_W-1:0] LOOK_TOP = ktw_pkg::GLYPH_W'(GLYPH_COUNT - 1);

  logic [ktw_pkg::VAL_W-1:0] mem [DEPTH];

  logic                        s1_valid_r;
  logic [ktw_pkg::OP_W-1:0]    s1_op_r;
  logic [ktw_pkg::CHAR_W-1:0]  s1_char_r;
  logic [ktw_pkg::IDX_W-1:0]   s1_idx_r;
  logic [ktw_pkg::VAL_W-1:0]   s1_val_r;

  logic [ktw_pkg::GLYPH_W-1:0] prev_r, prev_nxt;
  logic                        after_space_r, after_space_nxt;
  ktw_pkg::stage_t             st_r, st_nxt;

  logic                        is_sq, is_dq;
  logic [ktw_pkg::GLYPH_W-1:0] glyph, look, rd_glyph;
  logic                        we;
  logic [AW-1:0]               raddr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      s1_op_r   <= in_op;
      s1_char_r <= in_char;
      s1_idx_r  <= in_idx;
      s1_val_r  <= in_val;
    end
  end

  always_comb begin
    is_sq = (s1_char_r == ktw_pkg::CH_SQUOTE);
    is_dq = (s1_char_r == ktw_pkg::CH_DQUOTE);
    if (is_sq && after_space_r) begin
      glyph = ktw_pkg::CURLY_SINGLE;
    end else if (is_dq && after_space_r) begin
      glyph = ktw_pkg::CURLY_DOUBLE;
    end else begin
      glyph = ktw_pkg::clamp_code(s1_char_r, CHAR_TOP);
    end
    look = ktw_pkg::clamp_code(s1_char_r, LOOK_TOP);

    prev_nxt        = prev_r;
    after_space_nxt = after_space_r;
    st_nxt.valid    = s1_valid_r;
    st_nxt.kind     = ktw_pkg::KIND_NONE;
    rd_glyph        = glyph;
    we              = 1'b0;

    if (s1_valid_r) begin
      unique case (s1_op_r)
        ktw_pkg::OP_WRITE: begin
          we = ({{(32-ktw_pkg::IDX_W){1'b0}}, s1_idx_r} < 32'(DEPTH));
        end
        ktw_pkg::OP_CHAR: begin
          if (s1_char_r != ktw_pkg::CH_UNDERSCORE) begin
            if (!(is_sq || is_dq)) begin
              after_space_nxt = (glyph == '0);
            end
            if (glyph == '0) begin
              st_nxt.kind = ktw_pkg::KIND_SPACE;
            end else begin
              st_nxt.kind = ktw_pkg::KIND_KERN;
              prev_nxt    = glyph;
            end
          end
        end
        ktw_pkg::OP_END: begin
          st_nxt.kind     = ktw_pkg::KIND_END;
          rd_glyph        = look;
          prev_nxt        = '0;
          after_space_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end

    raddr = AW'(prev_r) * AW'(GLYPH_COUNT) + AW'(rd_glyph);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r        <= '0;
      after_space_r <= 1'b1;
      st_r          <= '{valid: 1'b0, kind: ktw_pkg::KIND_NONE};
    end else if (adv) begin
      prev_r        <= prev_nxt;
      after_space_r <= after_space_nxt;
      st_r          <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (we) begin
        mem[s1_idx_r[AW-1:0]] <= s1_val_r;
      end
      rd_data <= mem[raddr];
    end
  end

  assign st = st_r;

endmodule

FILE: rtl/core/ktw_accum.sv
// Space width register, saturating width accumulator and the result register.
// Depends on ktw_pkg; consumes the stage_t and table read data from ktw_front.
module ktw_accum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ktw_pkg::VAL_W-1:0]   cfg_wdata,
  input  ktw_pkg::stage_t             st,
  input  logic [ktw_pkg::VAL_W-1:0]   rd_data,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [ktw_pkg::SUM_W-1:0]   out_width,
  output logic                        adv
);

  logic [ktw_pkg::VAL_W-1:0] space_width_r;
  logic [ktw_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [ktw_pkg::SUM_W-1:0] out_width_r, out_width_nxt;
  logic [ktw_pkg::VAL_W:0]   amount;
  logic [ktw_pkg::SUM_W:0]   sum_wide;
  logic [ktw_pkg::SUM_W-1:0] sum_sat;
  logic                      is_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_width_r <= ktw_pkg::SPACE_WIDTH_RST;
    end else if (cfg_we) begin
      space_width_r <= cfg_wdata;
    end
  end

  always_comb begin
    is_end = st.valid && (st.kind == ktw_pkg::KIND_END);
    // only an end transaction needs a free result register
    adv    = !(is_end && out_valid_r && !out_ready);

    case (st.kind)
      ktw_pkg::KIND_SPACE: amount = {1'b0, space_width_r};
      ktw_pkg::KIND_KERN:  amount = {1'b0, rd_data} + {1'b0, ktw_pkg::KERN};
      ktw_pkg::KIND_END:   amount = {1'b0, rd_data};
      default:             amount = '0;
    endcase
    sum_wide = {1'b0, sum_r} + (ktw_pkg::SUM_W+1)'(amount);
    sum_sat  = sum_wide[ktw_pkg::SUM_W] ? '1 : sum_wide[ktw_pkg::SUM_W-1:0];

    sum_nxt       = sum_r;
    out_width_nxt = out_width_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (st.valid && adv) begin
      if (is_end) begin
        sum_nxt       = '0;
        out_width_nxt = sum_sat;
        out_valid_nxt = 1'b1;
      end else begin
        sum_nxt = sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_width_r <= out_width_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_width = out_width_r;

endmodule

FILE: rtl/core/ktw_checker.sv
// Port-level checks for kerned_text_width_measure, attached by bind.
// Depends on ktw_pkg for widths; sees only the top-level ports.
module ktw_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ktw_pkg::SUM_W-1:0]  out_width
);

  a_rst_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_cause: assert property (@(posedge clk) !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a waiting result");

  a_ready_when_empty: assert property (@(posedge clk) !out_valid |-> in_ready)
    else $error("input not ready with empty result register");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && !out_ready) |=> (out_valid && $stable(out_width)))
    else $error("result dropped or changed while stalled");

endmodule

bind kerned_text_width_measure ktw_checker u_ktw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_width (out_chan.string_width)
);
